### rtl/pti_pkg.sv
// Shared types and constants for the polar table interpolator.
package pti_pkg;

   localparam int ANGLE_W  = 11;
   localparam int SPEED_W  = 16;
   localparam int COURSE_W = 12;
   localparam int MULT_W   = 17;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = ANGLE_W + SPEED_W;
   localparam int PROD_W   = ANGLE_W + SPEED_W;
   localparam int NUM_W    = PROD_W + 1;
   localparam int FOLD_W   = COURSE_W + 1;
   localparam int QUOT_BITS = MULT_W;

   localparam logic [ANGLE_W-1:0]  ANGLE_MAX   = 11'd1800;
   localparam logic [COURSE_W-1:0] FULL_CIRCLE = 12'd3600;
   localparam logic [MULT_W-1:0]   ONE_Q16     = 17'h10000;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_LOAD  = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_NO_TABLE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_WALK,
      SEQ_SHIFT_RD,
      SEQ_SHIFT_WR,
      SEQ_INSERT,
      SEQ_MUL_LO,
      SEQ_MUL_HI,
      SEQ_MUL_DEN,
      SEQ_DIV_GO,
      SEQ_DIV_WAIT,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [MULT_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [MULT_W-1:0]  mult;
      logic [COUNT_W-1:0] count;
      status_type         status;
   } result_type;

endpackage

### rtl/pti_div.sv
// Iterative restoring divider: rounded Q1.16 ratio num/den, clamped to 1.0.
module pti_div (
   input  logic                clock,
   input  logic                reset,
   input  pti_pkg::div_req_type div_req,
   output pti_pkg::div_rsp_type div_rsp
);
   import pti_pkg::*;

   localparam int CNT_W = $clog2(QUOT_BITS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  den_ff, den_in;
   logic [MULT_W-1:0] q_ff, q_in;
   logic [MULT_W-1:0] quot_ff, quot_in;

   logic [NUM_W:0]    rem_shift;
   logic              fits;
   logic [MULT_W-1:0] q_next;
   logic [MULT_W:0]   q_round;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      fits      = rem_shift >= {1'b0, den_ff};
      q_next    = {q_ff[MULT_W-2:0], fits};
      // floor(N*2^17/D) then halve with +1 gives round half up of N*2^16/D
      q_round   = ({1'b0, q_next} + 1'b1) >> 1;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      quot_in = quot_ff;

      if (div_req.start) begin
         den_in = div_req.den;
         rem_in = div_req.num;
         q_in   = '0;
         cnt_in = CNT_W'(QUOT_BITS - 1);
         if (div_req.num >= div_req.den) begin
            done_in = 1'b1;
            quot_in = ONE_Q16;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = fits ? NUM_W'(rem_shift - {1'b0, den_ff}) : NUM_W'(rem_shift);
         q_in   = q_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quot_in = MULT_W'(q_round);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### rtl/pti_seq.sv
// Sequencer with the sorted angle table, the shared multiplier and the item datapath.
module pti_seq #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  pti_pkg::req_code_type          req_code,
   input  logic [pti_pkg::ANGLE_W-1:0]    entry_angle,
   input  logic [pti_pkg::SPEED_W-1:0]    entry_speed,
   input  logic [pti_pkg::COURSE_W-1:0]   candidate_course,
   input  logic [pti_pkg::COURSE_W-1:0]   wind_direction,
   output logic                           idle,
   output pti_pkg::result_type            res,
   input  logic                           res_take,
   output pti_pkg::div_req_type           div_req,
   input  pti_pkg::div_rsp_type           div_rsp
);
   import pti_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   seq_state_type state_ff, state_in;
   req_code_type  op_ff, op_in;

   logic [ANGLE_W-1:0]  rel_ff, rel_in;
   logic [SPEED_W-1:0]  spd_ff, spd_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [SPEED_W-1:0]  peak_ff, peak_in;
   logic [ANGLE_W-1:0]  lo_a_ff, lo_a_in, hi_a_ff, hi_a_in;
   logic [SPEED_W-1:0]  lo_s_ff, lo_s_in, hi_s_ff, hi_s_in;
   logic [NUM_W-1:0]    acc_ff, acc_in;
   logic [NUM_W-1:0]    den_ff, den_in;
   logic [MULT_W-1:0]   mult_ff, mult_in;
   status_type          status_ff, status_in;

   logic [ENTRY_W-1:0]  tbl_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]  rd_data_ff;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic                mem_we;

   logic [SPEED_W-1:0]  mul_a;
   logic [ANGLE_W-1:0]  mul_b;
   logic [PROD_W-1:0]   prod;

   logic [ANGLE_W-1:0]  key_a;
   logic [SPEED_W-1:0]  key_s;
   logic                walk_end, hit, below, full, no_table;
   logic [ANGLE_W-1:0]  span;

   logic [COURSE_W-1:0] c_mod, w_mod;
   logic signed [FOLD_W-1:0] diff, diff_w, lim;
   logic [FOLD_W-1:0]   mag;
   logic [ANGLE_W-1:0]  rel_q, ang_sat;

   assign key_a    = rd_data_ff[ENTRY_W-1:SPEED_W];
   assign key_s    = rd_data_ff[SPEED_W-1:0];
   assign walk_end = idx_ff == used_ff;
   assign hit      = !walk_end && key_a == rel_ff;
   assign below    = !walk_end && key_a < rel_ff;
   assign full     = used_ff == CW'(TABLE_DEPTH);
   assign no_table = used_ff == '0 || peak_ff == '0;
   assign span     = hi_a_ff - lo_a_ff;
   assign prod     = {{ANGLE_W{1'b0}}, mul_a} * {{SPEED_W{1'b0}}, mul_b};

   // fold heading minus wind into 0..1800
   always_comb begin
      c_mod  = (candidate_course >= FULL_CIRCLE) ? candidate_course - FULL_CIRCLE
                                                 : candidate_course;
      w_mod  = (wind_direction >= FULL_CIRCLE) ? wind_direction - FULL_CIRCLE
                                               : wind_direction;
      lim    = $signed({2'b00, ANGLE_MAX});
      diff   = $signed({1'b0, c_mod}) - $signed({1'b0, w_mod});
      if (diff < -lim) begin
         diff_w = diff + $signed({1'b0, FULL_CIRCLE});
      end else if (diff > lim) begin
         diff_w = diff - $signed({1'b0, FULL_CIRCLE});
      end else begin
         diff_w = diff;
      end
      mag     = (diff_w < 0) ? FOLD_W'(-diff_w) : FOLD_W'(diff_w);
      rel_q   = mag[ANGLE_W-1:0];
      ang_sat = (entry_angle > ANGLE_MAX) ? ANGLE_MAX : entry_angle;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               case (req_code)
                  REQ_LOAD:  state_in = SEQ_WALK;
                  REQ_QUERY: state_in = no_table ? SEQ_DONE : SEQ_WALK;
                  default:   state_in = SEQ_DONE;
               endcase
            end
         end
         SEQ_WALK: begin
            if (hit) begin
               state_in = (op_ff == REQ_LOAD) ? SEQ_DONE : SEQ_DIV_GO;
            end else if (!below) begin
               if (op_ff == REQ_LOAD) begin
                  state_in = full ? SEQ_DONE : SEQ_SHIFT_RD;
               end else begin
                  state_in = SEQ_MUL_LO;
               end
            end
         end
         SEQ_SHIFT_RD: state_in = (idx_ff == pos_ff) ? SEQ_INSERT : SEQ_SHIFT_WR;
         SEQ_SHIFT_WR: state_in = SEQ_SHIFT_RD;
         SEQ_INSERT:   state_in = SEQ_DONE;
         SEQ_MUL_LO:   state_in = SEQ_MUL_HI;
         SEQ_MUL_HI:   state_in = SEQ_MUL_DEN;
         SEQ_MUL_DEN:  state_in = SEQ_DIV_GO;
         SEQ_DIV_GO:   state_in = SEQ_DIV_WAIT;
         SEQ_DIV_WAIT: state_in = div_rsp.done ? SEQ_DONE : SEQ_DIV_WAIT;
         SEQ_DONE:     state_in = res_take ? SEQ_IDLE : SEQ_DONE;
         default:      state_in = SEQ_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      op_in     = op_ff;
      rel_in    = rel_ff;
      spd_in    = spd_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      used_in   = used_ff;
      peak_in   = peak_ff;
      lo_a_in   = lo_a_ff;
      lo_s_in   = lo_s_ff;
      hi_a_in   = hi_a_ff;
      hi_s_in   = hi_s_ff;
      acc_in    = acc_ff;
      den_in    = den_ff;
      mult_in   = mult_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = {rel_ff, spd_ff};
      rd_addr   = '0;
      mul_a     = '0;
      mul_b     = '0;

      div_req.start = 1'b0;
      div_req.num   = acc_ff;
      div_req.den   = den_ff;

      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               op_in     = req_code;
               rel_in    = (req_code == REQ_LOAD) ? ang_sat : rel_q;
               spd_in    = entry_speed;
               idx_in    = '0;
               lo_a_in   = '0;
               lo_s_in   = '0;
               hi_a_in   = ANGLE_MAX;
               hi_s_in   = '0;
               mult_in   = '0;
               status_in = STAT_OK;
               if (req_code == REQ_CLEAR) begin
                  used_in = '0;
                  peak_in = '0;
               end else if (req_code == REQ_QUERY && no_table) begin
                  mult_in   = ONE_Q16;
                  status_in = STAT_NO_TABLE;
               end
            end
         end
         SEQ_WALK: begin
            // prefetch the next entry; its word lands while this one is compared
            rd_addr = AW'(idx_ff + 1'b1);
            if (hit) begin
               if (op_ff == REQ_LOAD) begin
                  mem_we  = 1'b1;
                  wr_data = {key_a, spd_ff};
                  peak_in = (spd_ff > peak_ff) ? spd_ff : peak_ff;
               end else begin
                  acc_in = NUM_W'(key_s);
                  den_in = NUM_W'(peak_ff);
               end
            end else if (below) begin
               lo_a_in = key_a;
               lo_s_in = key_s;
               idx_in  = idx_ff + 1'b1;
            end else if (op_ff == REQ_LOAD) begin
               if (full) begin
                  status_in = STAT_FULL;
               end else begin
                  pos_in = idx_ff;
                  idx_in = used_ff;
               end
            end else if (!walk_end) begin
               hi_a_in = key_a;
               hi_s_in = key_s;
            end
         end
         SEQ_SHIFT_RD: begin
            rd_addr = AW'(idx_ff - 1'b1);
         end
         SEQ_SHIFT_WR: begin
            mem_we  = 1'b1;
            wr_data = rd_data_ff;
            idx_in  = idx_ff - 1'b1;
         end
         SEQ_INSERT: begin
            mem_we  = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            used_in = used_ff + 1'b1;
            peak_in = (spd_ff > peak_ff) ? spd_ff : peak_ff;
         end
         SEQ_MUL_LO: begin
            mul_a  = lo_s_ff;
            mul_b  = hi_a_ff - rel_ff;
            acc_in = NUM_W'(prod);
         end
         SEQ_MUL_HI: begin
            mul_a  = hi_s_ff;
            mul_b  = rel_ff - lo_a_ff;
            acc_in = NUM_W'(acc_ff + NUM_W'(prod));
         end
         SEQ_MUL_DEN: begin
            mul_a = peak_ff;
            mul_b = span;
            if (span == '0) begin
               acc_in = NUM_W'(lo_s_ff);
               den_in = NUM_W'(peak_ff);
            end else begin
               den_in = NUM_W'(prod);
            end
         end
         SEQ_DIV_GO: begin
            div_req.start = 1'b1;
         end
         SEQ_DIV_WAIT: begin
            if (div_rsp.done) begin
               mult_in = div_rsp.quot;
            end
         end
         SEQ_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         used_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         peak_ff  <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rel_ff    <= rel_in;
      spd_ff    <= spd_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      lo_a_ff   <= lo_a_in;
      lo_s_ff   <= lo_s_in;
      hi_a_ff   <= hi_a_in;
      hi_s_ff   <= hi_s_in;
      acc_ff    <= acc_in;
      den_ff    <= den_in;
      mult_ff   <= mult_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   assign idle       = state_ff == SEQ_IDLE;
   assign res.valid  = state_ff == SEQ_DONE;
   assign res.mult   = mult_ff;
   assign res.count  = COUNT_W'(used_ff);
   assign res.status = status_ff;

endmodule

### rtl/polar_table_interpolator.sv
// Polar table interpolator top level: handshakes, result register, checks.
// Takes one word at a time. Clear and no-op words go straight to the done
// state. A load walks the sorted table one entry a cycle until it finds its
// place, then (unless its angle is already held) shifts every entry above
// that place up by one, a read and a write state per entry, through the
// table memory with one read and one write port. The walk and the shift
// split the N entries held between them, so the worst case is an insert at
// the bottom of the table. A query walks the table the same way, runs three
// passes through the one shared 16x11 multiplier (none on an exact angle
// hit) and a 17-step divider. A query on an empty table or with a peak speed
// of zero returns 1.0 with status 2. The table memory needs no clearing after
// reset. req_stall is high while a word is in work, and also while a finished
// word waits for the result register to free up; a word already sitting in
// the result register does not hold up the next request.
module polar_table_interpolator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [pti_pkg::ANGLE_W-1:0]   req_entry_angle,
   input  logic [pti_pkg::SPEED_W-1:0]   req_entry_speed,
   input  logic [pti_pkg::COURSE_W-1:0]  req_candidate_course,
   input  logic [pti_pkg::COURSE_W-1:0]  req_wind_direction,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pti_pkg::MULT_W-1:0]    rsp_multiplier,
   output logic [pti_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [pti_pkg::STATUS_W-1:0]  rsp_status
);
   import pti_pkg::*;

   logic        seq_idle;
   logic        start;
   logic        take;
   result_type  res;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [MULT_W-1:0]  rsp_mult_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   assign req_stall = !seq_idle;
   assign start     = req_valid && seq_idle;
   assign take      = res.valid && (!rsp_valid_ff || !rsp_stall);

   pti_seq #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_code         (req_code_type'(req_type)),
      .entry_angle      (req_entry_angle),
      .entry_speed      (req_entry_speed),
      .candidate_course (req_candidate_course),
      .wind_direction   (req_wind_direction),
      .idle             (seq_idle),
      .res              (res),
      .res_take         (take),
      .div_req          (div_req),
      .div_rsp          (div_rsp)
   );

   pti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_mult_ff   <= res.mult;
         rsp_count_ff  <= res.count;
         rsp_status_ff <= res.status;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_multiplier  = rsp_mult_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   // an accepted word keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while idle did not make the block busy");

   // a new result only follows a word that was in work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result word appeared with no request in work");

   // no valid table always reports full scale
   a_no_table_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_NO_TABLE) |-> rsp_multiplier == ONE_Q16)
      else $error("no-table status with multiplier other than 1.0");

   // a dropped load carries no multiplier
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_FULL) |-> rsp_multiplier == '0)
      else $error("dropped load reported a nonzero multiplier");

endmodule
